FILE: hdl/touch_grid_calibration_mapper_assert.svh
// assertion macros used by the touch grid mapper checker
`ifndef TOUCH_GRID_CALIBRATION_MAPPER_ASSERT_SVH
`define TOUCH_GRID_CALIBRATION_MAPPER_ASSERT_SVH
// same-cycle implication, sampled on clk, off during reset
`define TGCM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tgcm check failed");
// next-cycle implication, sampled on clk, off during reset
`define TGCM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tgcm check failed");
`endif

FILE: hdl/tgcm_pkg.sv
// constants and types of the touch grid calibration mapper
package tgcm_pkg;
    localparam int GRID_COLS  = 9;
    localparam int GRID_ROWS  = 7;
    localparam int CELL_SCALE = 40;
    localparam int DATA_W     = 16;
    localparam int COL_W      = 4;
    localparam int ROW_W      = 3;
    localparam int DEPTH      = GRID_COLS * GRID_ROWS;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int COLC_W     = $clog2(GRID_COLS);
    localparam int ROWC_W     = $clog2(GRID_ROWS);
    localparam int SUMX_W     = DATA_W + $clog2(GRID_ROWS);
    localparam int SUMY_W     = DATA_W + $clog2(GRID_COLS);
    localparam int MAXDIM     = (GRID_COLS > GRID_ROWS) ? GRID_COLS : GRID_ROWS;
    localparam int T_W        = DATA_W + $clog2(MAXDIM) + 1;
    localparam int NUM_W      = DATA_W + $clog2(MAXDIM) + $clog2(CELL_SCALE + 1);
    localparam int CNT_W      = $clog2(NUM_W + 1);
    localparam int TOP_X      = CELL_SCALE * (GRID_COLS - 1);
    localparam int TOP_Y      = CELL_SCALE * (GRID_ROWS - 1);
    localparam int SX_W       = $clog2(TOP_X + 1);
    localparam int SY_W       = $clog2(TOP_Y + 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUM,
        ST_ROWSEL,
        ST_FETCHA,
        ST_FETCHB,
        ST_FETCHC,
        ST_PREP,
        ST_LDX,
        ST_DIVX,
        ST_ENDX,
        ST_LDY,
        ST_DIVY,
        ST_ENDY,
        ST_DONE
    } state_t;
endpackage

FILE: hdl/tgcm_ram.sv
// generic simple dual port ram with registered read
module tgcm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: hdl/touch_grid_calibration_mapper.sv
// touch grid calibration mapper top level
// Load items write one raw reference point into the x and y reference RAMs and do not
// stall the input; every grid point must be loaded before a map item reads it. A map item
// stalls the input from its transfer until its result enters the output register. The
// column and row averages come from one serial scan of both RAMs, one entry per cycle,
// then four reads fetch the selected cell corners and one bit-serial divider, shared by the
// x and y axes, produces one quotient bit per cycle; an axis whose cell has zero width skips
// its division. A new item is taken only after the previous map result has been placed in
// the output register; that register may still be waiting for the sink, whose stalls then
// hold the map result back and so lengthen the input stall.
module touch_grid_calibration_mapper (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         kind,
    input  logic [tgcm_pkg::COL_W-1:0]   grid_col,
    input  logic [tgcm_pkg::ROW_W-1:0]   grid_row,
    input  logic [tgcm_pkg::DATA_W-1:0]  raw_x,
    input  logic [tgcm_pkg::DATA_W-1:0]  raw_y,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [tgcm_pkg::SX_W-1:0]    screen_x,
    output logic [tgcm_pkg::SY_W-1:0]    screen_y,
    output logic                         degenerate
);
    import tgcm_pkg::*;

    state_t                    state_reg, state_next;
    logic [COLC_W-1:0]         col_reg, col_next, col_d_reg, col_d_next;
    logic [ROWC_W-1:0]         row_reg, row_next, row_d_reg, row_d_next;
    logic [ADDR_W-1:0]         addr_reg, addr_next;
    logic                      iss_done_reg, iss_done_next;
    logic                      rd_v_reg, rd_v_next;
    logic [SUMX_W-1:0]         accx_reg, accx_next;
    logic [SUMY_W-1:0]         accy_reg [GRID_ROWS];
    logic [SUMY_W-1:0]         accy_next [GRID_ROWS];
    logic [COLC_W-1:0]         ci_reg, ci_next;
    logic [ROWC_W-1:0]         rj_reg, rj_next;
    logic [DATA_W-1:0]         sx_reg, sx_next, sy_reg, sy_next;
    logic [ADDR_W-1:0]         base_reg, base_next;
    logic [DATA_W-1:0]         xa_reg, xa_next, ya_reg, ya_next;
    logic [DATA_W-1:0]         xb_reg, xb_next, yb_reg, yb_next;
    logic signed [DATA_W:0]    dx_reg, dx_next, dy_reg, dy_next;
    logic signed [T_W-1:0]     tx_reg, tx_next, ty_reg, ty_next;
    logic [NUM_W-1:0]          q_reg, q_next;
    logic [DATA_W-1:0]         rem_reg, rem_next, den_reg, den_next;
    logic                      neg_reg, neg_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic [SX_W-1:0]           ox_reg, ox_next;
    logic [SY_W-1:0]           oy_reg, oy_next;
    logic                      degen_reg, degen_next;
    logic                      out_valid_reg, out_valid_next;
    logic [SX_W-1:0]           sxo_reg, sxo_next;
    logic [SY_W-1:0]           syo_reg, syo_next;
    logic                      dgo_reg, dgo_next;

    logic                      we;
    logic [ADDR_W-1:0]         waddr, raddr_x, raddr_y;
    logic [DATA_W-1:0]         rdata_x, rdata_y;

    logic [SUMX_W-1:0]         sumx_full, thr_x;
    logic [SUMY_W-1:0]         sumy_full, thr_y;
    logic [ROWC_W-1:0]         rj_sel;
    logic signed [DATA_W:0]    dcx, dcy;
    logic [DATA_W:0]           rem_sh, diff;
    logic                      ge;
    logic [T_W-1:0]            tmag;
    logic [NUM_W-1:0]          qsat;

    tgcm_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram_x (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (raw_x),
        .raddr (raddr_x),
        .rdata (rdata_x)
    );

    tgcm_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram_y (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (raw_y),
        .raddr (raddr_y),
        .rdata (rdata_y)
    );

    assign in_stall   = (state_reg != ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign screen_x   = sxo_reg;
    assign screen_y   = syo_reg;
    assign degenerate = dgo_reg;

    assign waddr = ADDR_W'(int'(grid_col) * GRID_ROWS + int'(grid_row));
    assign we    = in_valid && !in_stall && !kind
                   && (int'(grid_col) < GRID_COLS) && (int'(grid_row) < GRID_ROWS);

    // avg <= s  is the same as  sum <= n*s + n-1, so no divider is needed
    assign thr_x = SUMX_W'(GRID_ROWS * int'(sx_reg) + GRID_ROWS - 1);
    assign thr_y = SUMY_W'(GRID_COLS * int'(sy_reg) + GRID_COLS - 1);
    assign sumx_full = ((row_d_reg == '0) ? '0 : accx_reg) + SUMX_W'(rdata_x);
    assign sumy_full = ((col_d_reg == '0) ? '0 : accy_reg[row_d_reg]) + SUMY_W'(rdata_y);

    always_comb
    begin
        rj_sel = '0;
        for (int r = 0; r < GRID_ROWS - 1; r++)
        begin
            if (accy_reg[r] <= thr_y)
            begin
                rj_sel = ROWC_W'(r);
            end
        end
    end

    assign dcx = $signed({1'b0, xb_reg}) - $signed({1'b0, xa_reg});
    assign dcy = $signed({1'b0, yb_reg}) - $signed({1'b0, ya_reg});

    // one restoring division step
    assign rem_sh = {rem_reg, q_reg[NUM_W-1]};
    assign diff   = rem_sh - {1'b0, den_reg};
    assign ge     = (rem_sh >= {1'b0, den_reg});

    // negative quotients clamp to zero, large ones to the top edge
    always_comb
    begin
        if (state_reg == ST_ENDX)
        begin
            qsat = (q_reg > NUM_W'(TOP_X)) ? NUM_W'(TOP_X) : q_reg;
        end
        else
        begin
            qsat = (q_reg > NUM_W'(TOP_Y)) ? NUM_W'(TOP_Y) : q_reg;
        end
        if (neg_reg)
        begin
            qsat = '0;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        col_d_next     = col_d_reg;
        row_d_next     = row_d_reg;
        addr_next      = addr_reg;
        iss_done_next  = iss_done_reg;
        rd_v_next      = 1'b0;
        accx_next      = accx_reg;
        accy_next      = accy_reg;
        ci_next        = ci_reg;
        rj_next        = rj_reg;
        sx_next        = sx_reg;
        sy_next        = sy_reg;
        base_next      = base_reg;
        xa_next        = xa_reg;
        ya_next        = ya_reg;
        xb_next        = xb_reg;
        yb_next        = yb_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        tx_next        = tx_reg;
        ty_next        = ty_reg;
        q_next         = q_reg;
        rem_next       = rem_reg;
        den_next       = den_reg;
        neg_next       = neg_reg;
        cnt_next       = cnt_reg;
        ox_next        = ox_reg;
        oy_next        = oy_reg;
        degen_next     = degen_reg;
        sxo_next       = sxo_reg;
        syo_next       = syo_reg;
        dgo_next       = dgo_reg;
        out_valid_next = out_valid_reg && out_stall;
        raddr_x        = addr_reg;
        raddr_y        = addr_reg;
        tmag           = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && kind)
                begin
                    sx_next       = raw_x;
                    sy_next       = raw_y;
                    col_next      = '0;
                    row_next      = '0;
                    addr_next     = '0;
                    iss_done_next = 1'b0;
                    ci_next       = '0;
                    degen_next    = 1'b0;
                    state_next    = ST_SUM;
                end
            end
            ST_SUM:
            begin
                if (!iss_done_reg)
                begin
                    rd_v_next  = 1'b1;
                    col_d_next = col_reg;
                    row_d_next = row_reg;
                    addr_next  = addr_reg + 1'b1;
                    if (row_reg == ROWC_W'(GRID_ROWS - 1))
                    begin
                        row_next = '0;
                        if (col_reg == COLC_W'(GRID_COLS - 1))
                        begin
                            iss_done_next = 1'b1;
                        end
                        else
                        begin
                            col_next = col_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        row_next = row_reg + 1'b1;
                    end
                end
                if (rd_v_reg)
                begin
                    accx_next = sumx_full;
                    accy_next[row_d_reg] = sumy_full;
                    if (row_d_reg == ROWC_W'(GRID_ROWS - 1)
                        && col_d_reg != COLC_W'(GRID_COLS - 1) && sumx_full <= thr_x)
                    begin
                        ci_next = col_d_reg;
                    end
                    if (row_d_reg == ROWC_W'(GRID_ROWS - 1)
                        && col_d_reg == COLC_W'(GRID_COLS - 1))
                    begin
                        state_next = ST_ROWSEL;
                    end
                end
            end
            ST_ROWSEL:
            begin
                rj_next    = rj_sel;
                base_next  = ADDR_W'(int'(ci_reg) * GRID_ROWS + int'(rj_sel));
                state_next = ST_FETCHA;
            end
            ST_FETCHA:
            begin
                raddr_x    = base_reg;
                raddr_y    = base_reg;
                state_next = ST_FETCHB;
            end
            ST_FETCHB:
            begin
                raddr_x    = base_reg + ADDR_W'(GRID_ROWS);
                raddr_y    = base_reg + 1'b1;
                xa_next    = rdata_x;
                ya_next    = rdata_y;
                state_next = ST_FETCHC;
            end
            ST_FETCHC:
            begin
                xb_next    = rdata_x;
                yb_next    = rdata_y;
                state_next = ST_PREP;
            end
            ST_PREP:
            begin
                dx_next = dcx;
                dy_next = dcy;
                tx_next = T_W'(int'(ci_reg) * int'(dcx) + int'(sx_reg) - int'(xa_reg));
                ty_next = T_W'(int'(rj_reg) * int'(dcy) + int'(sy_reg) - int'(ya_reg));
                state_next = ST_LDX;
            end
            ST_LDX:
            begin
                if (dx_reg == '0)
                begin
                    degen_next = 1'b1;
                    ox_next    = SX_W'(CELL_SCALE * int'(ci_reg));
                    state_next = ST_LDY;
                end
                else
                begin
                    tmag       = tx_reg[T_W-1] ? T_W'(-tx_reg) : T_W'(tx_reg);
                    q_next     = NUM_W'(CELL_SCALE * int'(tmag));
                    rem_next   = '0;
                    den_next   = dx_reg[DATA_W] ? DATA_W'(-dx_reg) : DATA_W'(dx_reg);
                    neg_next   = tx_reg[T_W-1] ^ dx_reg[DATA_W];
                    cnt_next   = '0;
                    state_next = ST_DIVX;
                end
            end
            ST_DIVX, ST_DIVY:
            begin
                rem_next = ge ? diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
                q_next   = {q_reg[NUM_W-2:0], ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NUM_W - 1))
                begin
                    state_next = (state_reg == ST_DIVX) ? ST_ENDX : ST_ENDY;
                end
            end
            ST_ENDX:
            begin
                ox_next    = SX_W'(qsat);
                state_next = ST_LDY;
            end
            ST_LDY:
            begin
                if (dy_reg == '0)
                begin
                    degen_next = 1'b1;
                    oy_next    = SY_W'(CELL_SCALE * int'(rj_reg));
                    state_next = ST_DONE;
                end
                else
                begin
                    tmag       = ty_reg[T_W-1] ? T_W'(-ty_reg) : T_W'(ty_reg);
                    q_next     = NUM_W'(CELL_SCALE * int'(tmag));
                    rem_next   = '0;
                    den_next   = dy_reg[DATA_W] ? DATA_W'(-dy_reg) : DATA_W'(dy_reg);
                    neg_next   = ty_reg[T_W-1] ^ dy_reg[DATA_W];
                    cnt_next   = '0;
                    state_next = ST_DIVY;
                end
            end
            ST_ENDY:
            begin
                oy_next    = SY_W'(qsat);
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    sxo_next       = ox_reg;
                    syo_next       = oy_reg;
                    dgo_next       = degen_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            col_reg       <= '0;
            row_reg       <= '0;
            addr_reg      <= '0;
            iss_done_reg  <= 1'b0;
            rd_v_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            addr_reg      <= addr_next;
            iss_done_reg  <= iss_done_next;
            rd_v_reg      <= rd_v_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_d_reg <= col_d_next;
        row_d_reg <= row_d_next;
        accx_reg  <= accx_next;
        accy_reg  <= accy_next;
        ci_reg    <= ci_next;
        rj_reg    <= rj_next;
        sx_reg    <= sx_next;
        sy_reg    <= sy_next;
        base_reg  <= base_next;
        xa_reg    <= xa_next;
        ya_reg    <= ya_next;
        xb_reg    <= xb_next;
        yb_reg    <= yb_next;
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        tx_reg    <= tx_next;
        ty_reg    <= ty_next;
        q_reg     <= q_next;
        rem_reg   <= rem_next;
        den_reg   <= den_next;
        neg_reg   <= neg_next;
        ox_reg    <= ox_next;
        oy_reg    <= oy_next;
        degen_reg <= degen_next;
        sxo_reg   <= sxo_next;
        syo_reg   <= syo_next;
        dgo_reg   <= dgo_next;
    end
endmodule

FILE: hdl/tgcm_checker.sv
// port level checker for the touch grid calibration mapper and its bind
`include "touch_grid_calibration_mapper_assert.svh"

module tgcm_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  logic                        kind,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  logic [tgcm_pkg::SX_W-1:0]   screen_x,
    input  logic [tgcm_pkg::SY_W-1:0]   screen_y,
    input  logic                        degenerate
);
    import tgcm_pkg::*;

    `TGCM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(screen_x) && $stable(screen_y) && $stable(degenerate))
    `TGCM_ASSERT_NOW(a_out_range, out_valid, (screen_x <= SX_W'(TOP_X)) && (screen_y <= SY_W'(TOP_Y)))
    `TGCM_ASSERT_NEXT(a_map_busy, in_valid && !in_stall && kind, in_stall)
    `TGCM_ASSERT_NEXT(a_load_free, in_valid && !in_stall && !kind, !in_stall)
endmodule

bind touch_grid_calibration_mapper tgcm_checker u_tgcm_checker (.*);

FILE: test/touch_grid_calibration_mapper_tb.sv
// self-checking testbench for the touch grid calibration mapper
module touch_grid_calibration_mapper_tb;
    import tgcm_pkg::*;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_MAP  = 1'b1;
    localparam int   CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic              kind;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [DATA_W-1:0] x;
        logic [DATA_W-1:0] y;
    } touch_item_t;

    typedef struct packed {
        logic [SX_W-1:0] sx;
        logic [SY_W-1:0] sy;
        logic            degen;
    } screen_pos_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic kind;
    logic [COL_W-1:0] grid_col;
    logic [ROW_W-1:0] grid_row;
    logic [DATA_W-1:0] raw_x;
    logic [DATA_W-1:0] raw_y;
    logic out_valid;
    logic out_stall;
    logic [SX_W-1:0] screen_x;
    logic [SY_W-1:0] screen_y;
    logic degenerate;

    touch_item_t pending_items[$];
    screen_pos_t expected_positions[$];
    logic [DATA_W-1:0] grid_x[DEPTH];
    logic [DATA_W-1:0] grid_y[DEPTH];
    int mismatch_count = 0;
    int map_count = 0;
    int degen_count = 0;
    int load_count = 0;
    int cycle_count = 0;
    int burst_left = 0;
    int gap_left = 0;
    int hold_off_cycles = 0;
    bit stimulus_done = 0;
    bit in_taken = 0;

    touch_grid_calibration_mapper dut (.*);

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    task automatic report(input string what, input int got, input int want);
        $display("mismatch on %s: got %0d expected %0d", what, got, want);
        mismatch_count++;
    endtask

    // one axis: cell index, interpolated position, zero-width flag
    function automatic longint axis_position(input int idx, input int sample, input int a,
                                             input int b, input int n, inout bit degen);
        longint d;
        longint v;
        d = longint'(b) - longint'(a);
        if (d == 0)
        begin
            degen = 1'b1;
            v = CELL_SCALE * idx;
        end
        else
            v = (CELL_SCALE * (idx * d + sample - a)) / d;
        if (v < 0)
            v = 0;
        if (v > CELL_SCALE * (n - 1))
            v = CELL_SCALE * (n - 1);
        return v;
    endfunction

    task automatic apply_touch(input touch_item_t it);
        int avg_x[GRID_COLS];
        int avg_y[GRID_ROWS];
        int sum;
        int ci;
        int rj;
        bit degen;
        screen_pos_t p;
        if (it.kind == KIND_LOAD)
        begin
            if (it.col < GRID_COLS && it.row < GRID_ROWS)
            begin
                grid_x[it.col * GRID_ROWS + it.row] = it.x;
                grid_y[it.col * GRID_ROWS + it.row] = it.y;
                load_count++;
            end
            return;
        end
        for (int c = 0; c < GRID_COLS; c++)
        begin
            sum = 0;
            for (int r = 0; r < GRID_ROWS; r++)
                sum += grid_x[c * GRID_ROWS + r];
            avg_x[c] = sum / GRID_ROWS;
        end
        for (int r = 0; r < GRID_ROWS; r++)
        begin
            sum = 0;
            for (int c = 0; c < GRID_COLS; c++)
                sum += grid_y[c * GRID_ROWS + r];
            avg_y[r] = sum / GRID_COLS;
        end
        ci = 0;
        rj = 0;
        for (int c = 0; c < GRID_COLS - 1; c++)
            if (int'(it.x) >= avg_x[c])
                ci = c;
        for (int r = 0; r < GRID_ROWS - 1; r++)
            if (int'(it.y) >= avg_y[r])
                rj = r;
        degen = 1'b0;
        p.sx = SX_W'(axis_position(ci, it.x, grid_x[ci * GRID_ROWS + rj],
                                   grid_x[(ci + 1) * GRID_ROWS + rj], GRID_COLS, degen));
        p.sy = SY_W'(axis_position(rj, it.y, grid_y[ci * GRID_ROWS + rj],
                                   grid_y[ci * GRID_ROWS + rj + 1], GRID_ROWS, degen));
        p.degen = degen;
        if (degen)
            degen_count++;
        map_count++;
        expected_positions.push_back(p);
    endtask

    function automatic touch_item_t make_item(input logic k, input int col, input int row,
                                              input int x, input int y);
        touch_item_t it;
        it.kind = k;
        it.col = COL_W'(col);
        it.row = ROW_W'(row);
        it.x = DATA_W'(x);
        it.y = DATA_W'(y);
        return it;
    endfunction

    // style: 0 regular increasing, 1 flat (zero-width), 2 decreasing, 3 random
    task automatic queue_grid(input int style);
        int x;
        int y;
        for (int c = 0; c < GRID_COLS; c++)
            for (int r = 0; r < GRID_ROWS; r++)
            begin
                case (style)
                    0:
                    begin
                        x = 2000 + c * 7000 + $urandom_range(0, 600);
                        y = 3000 + r * 9000 + $urandom_range(0, 600);
                    end
                    1:
                    begin
                        x = (c < 4) ? 30000 : 30000 + c * 3000;
                        y = (r < 3) ? 20000 : 20000 + r * 5000;
                    end
                    2:
                    begin
                        x = 64000 - c * 7500 - $urandom_range(0, 500);
                        y = 63000 - r * 9500 - $urandom_range(0, 500);
                    end
                    default:
                    begin
                        x = $urandom_range(0, 65535);
                        y = $urandom_range(0, 65535);
                    end
                endcase
                pending_items.push_back(make_item(KIND_LOAD, c, r, x, y));
            end
    endtask

    initial
    begin
        touch_item_t it;
        int style;
        // directed: full increasing grid with corner values, then edge samples
        for (int c = 0; c < GRID_COLS; c++)
            for (int r = 0; r < GRID_ROWS; r++)
                pending_items.push_back(make_item(KIND_LOAD, c, r,
                    (c == 0 && r == 0) ? 0 : c * 8000 + r,
                    (c == GRID_COLS - 1 && r == GRID_ROWS - 1) ? 65535 : r * 10000 + c));
        // out-of-range loads are dropped
        pending_items.push_back(make_item(KIND_LOAD, 15, 7, 16'hffff, 16'hffff));
        pending_items.push_back(make_item(KIND_LOAD, 9, 0, 0, 0));
        pending_items.push_back(make_item(KIND_LOAD, 0, 7, 0, 0));
        pending_items.push_back(make_item(KIND_MAP, 0, 0, 0, 0));
        pending_items.push_back(make_item(KIND_MAP, 15, 7, 65535, 65535));
        pending_items.push_back(make_item(KIND_MAP, 5, 3, 32768, 30000));
        pending_items.push_back(make_item(KIND_MAP, 10, 2, 8000, 10000));
        pending_items.push_back(make_item(KIND_MAP, 0, 5, 21845, 43690));
        // random phases: grid reload then samples, with stray noise loads
        for (int ph = 0; ph < 6; ph++)
        begin
            style = (ph < 4) ? ph : $urandom_range(0, 3);
            queue_grid(style);
            for (int i = 0; i < 33; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                    it = make_item(KIND_LOAD, $urandom_range(9, 15), $urandom_range(0, 7),
                                   $urandom_range(0, 65535), $urandom_range(0, 65535));
                else
                    it = make_item(KIND_MAP, $urandom_range(0, 15), $urandom_range(0, 7),
                                   ($urandom_range(0, 7) == 0) ? 65535 * $urandom_range(0, 1)
                                                               : $urandom_range(0, 65535),
                                   ($urandom_range(0, 7) == 0) ? 65535 * $urandom_range(0, 1)
                                                               : $urandom_range(0, 65535));
                pending_items.push_back(it);
            end
        end
    end

    // remembers whether the offered item was taken at the last rising edge
    always @(posedge clk)
        in_taken <= in_valid && !in_stall;

    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            kind <= KIND_LOAD;
            grid_col <= '0;
            grid_row <= '0;
            raw_x <= '0;
            raw_y <= '0;
        end
        else if (!in_valid || in_taken)
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                it_drive(pending_items.pop_front());
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 300);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
            begin
                in_valid <= 1'b0;
                stimulus_done <= 1'b1;
            end
        end
    end

    task automatic it_drive(input touch_item_t it);
        in_valid <= 1'b1;
        kind <= it.kind;
        grid_col <= it.col;
        grid_row <= it.row;
        raw_x <= it.x;
        raw_y <= it.y;
    endtask

    // sink stall pattern, with one long hold-off early in the run
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (map_count >= 3 && map_count < 6 && hold_off_cycles < 3000)
        begin
            hold_off_cycles <= hold_off_cycles + 1;
            out_stall <= 1'b1;
        end
        else if ((cycle_count / 2000) % 3 == 0)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(0, 99) < 60);
    end

    always @(posedge clk)
    begin
        screen_pos_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                apply_touch('{kind, grid_col, grid_row, raw_x, raw_y});
            if (out_valid && !out_stall)
            begin
                if (expected_positions.size() == 0)
                    report("unexpected result", 1, 0);
                else
                begin
                    want = expected_positions.pop_front();
                    if (screen_x !== want.sx)
                        report("screen_x", screen_x, want.sx);
                    if (screen_y !== want.sy)
                        report("screen_y", screen_y, want.sy);
                    if (degenerate !== want.degen)
                        report("degenerate", degenerate, want.degen);
                end
            end
        end
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n = 1'b1;
        fork
            begin
                wait (stimulus_done && expected_positions.size() == 0);
                repeat (300) @(posedge clk);
            end
            wait (cycle_count >= CYCLE_LIMIT);
        join_any
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout with %0d results outstanding", expected_positions.size());
            $display("end of test: mismatches");
        end
        else
        begin
            if (expected_positions.size() != 0)
                report("results left over", expected_positions.size(), 0);
            $display("covered %0d grid loads and %0d mapped samples, %0d on flat cells",
                     load_count, map_count, degen_count);
            if (mismatch_count == 0)
                $display("end of test: clean");
            else
                $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
